// File: src/lpr_pkg.sv
// Shared types, widths and codes for the locked page range set unit.
package lpr_pkg;

  // Address and page geometry
  localparam int ADDR_BITS  = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int PG_W       = ADDR_BITS - PAGE_SHIFT;     // stored start page
  localparam int END_W      = PG_W + 1;                   // stored end page
  localparam int LEN_W      = ADDR_BITS + 1;              // byte length field
  localparam int SUM_AL_W   = ADDR_BITS + 2;              // addr + len (+ page round)
  localparam int OPPG_W     = SUM_AL_W - PAGE_SHIFT;      // operation page bounds
  localparam int BYTE_W     = ADDR_BITS + 3;              // byte bounds and sums
  localparam int QUOTA_W    = 64;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int REGION_W   = 49;
  localparam int TOTAL_W    = 49;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int DEF_RANGE_SLOTS = 1024;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 3'd0,
    FUNC_DEL   = 3'd1,
    FUNC_QUERY = 3'd2,
    FUNC_GATE  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  // Gate verdicts
  typedef enum logic [STATUS_W-1:0] {
    GATE_OK     = 2'd0,
    GATE_FORBID = 2'd1,
    GATE_OVER   = 2'd2
  } gate_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_ALL = 2'd1;

  // One stored range, in pages, [start_pg, end_pg)
  typedef struct packed {
    logic [PG_W-1:0]  start_pg;
    logic [END_W-1:0] end_pg;
  } range_t;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic shift;
    logic wr_en;
  } cell_ctrl_t;

  // Words fed to the sum pipelines
  typedef struct packed {
    logic   clr;
    logic   cov_vld;
    range_t cov_rng;
    logic   sto_vld;
    range_t sto_rng;
  } acc_in_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_TAIL,
    ST_APPEND,
    ST_DRAIN,
    ST_FRESH,
    ST_DONE
  } state_e;

endpackage

// File: src/lpr_if.sv
// Valid/ready channel interfaces for operation words and result words.
interface lpr_in_if;
  import lpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ADDR_BITS-1:0] start_addr;
  logic [LEN_W-1:0]     length;

  modport source (output valid, func, start_addr, length, input ready);
  modport sink   (input valid, func, start_addr, length, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [REGION_W-1:0] region_bytes;
  logic [TOTAL_W-1:0]  total_locked;
  logic [COUNT_W-1:0]  range_count;
  logic                dropped;

  modport source (output valid, status, region_bytes, total_locked, range_count, dropped,
                  input ready);
  modport sink   (input valid, status, region_bytes, total_locked, range_count, dropped,
                  output ready);
endinterface

// File: src/lpr_cell.sv
// One storage cell of the range chain: load, take from neighbor, or hold.
module lpr_cell
  import lpr_pkg::*;
#(
  parameter int IDX_W    = 10,
  parameter int CELL_IDX = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  range_t           wr_data_i,
  input  range_t           next_i,
  output range_t           data_o
);

  range_t data_d, data_q;
  logic   sel;

  // Pick load, shift or hold
  assign sel = ctrl_i.wr_en && (wr_idx_i == IDX_W'(CELL_IDX));

  always_comb begin
    if (sel) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: src/lpr_accum.sv
// Pipelined sums: locked bytes inside a window and bytes of written ranges.
module lpr_accum
  import lpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_in_t           acc_i,
  input  logic [BYTE_W-1:0] lo_i,
  input  logic [BYTE_W-1:0] hi_i,
  output logic [BYTE_W-1:0] cov_sum_o,
  output logic [BYTE_W-1:0] sto_sum_o
);

  logic [BYTE_W-1:0] ab, bb, cl_d, ch_d;
  logic              c1_vld_q, s1_vld_q;
  logic [BYTE_W-1:0] cl_q, ch_q;
  range_t            s1_rng_q;
  logic [BYTE_W-1:0] cd_d, cd_q;
  logic [END_W-1:0]  sd_d, sd_q;
  logic [BYTE_W-1:0] cov_sum_q, sto_sum_q;

  // Clip the entry to the window
  assign ab   = BYTE_W'({acc_i.cov_rng.start_pg, {PAGE_SHIFT{1'b0}}});
  assign bb   = BYTE_W'({acc_i.cov_rng.end_pg, {PAGE_SHIFT{1'b0}}});
  assign cl_d = (ab > lo_i) ? ab : lo_i;
  assign ch_d = (bb < hi_i) ? bb : hi_i;

  // Overlap width and page length
  assign cd_d = (c1_vld_q && (ch_q > cl_q)) ? (ch_q - cl_q) : '0;
  assign sd_d = s1_vld_q ? (s1_rng_q.end_pg - END_W'(s1_rng_q.start_pg)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      cd_q      <= '0;
      sd_q      <= '0;
      cov_sum_q <= '0;
      sto_sum_q <= '0;
    end else if (acc_i.clr) begin
      c1_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      cd_q      <= '0;
      sd_q      <= '0;
      cov_sum_q <= '0;
      sto_sum_q <= '0;
    end else begin
      c1_vld_q  <= acc_i.cov_vld;
      s1_vld_q  <= acc_i.sto_vld;
      cd_q      <= cd_d;
      sd_q      <= sd_d;
      cov_sum_q <= cov_sum_q + cd_q;
      sto_sum_q <= sto_sum_q + BYTE_W'({sd_q, {PAGE_SHIFT{1'b0}}});
    end
  end

  // Payload stage, no reset
  always_ff @(posedge clk_i) begin
    cl_q     <= cl_d;
    ch_q     <= ch_d;
    s1_rng_q <= acc_i.sto_rng;
  end

  assign cov_sum_o = cov_sum_q;
  assign sto_sum_o = sto_sum_q;

endmodule

// File: src/locked_page_range_set_unit.sv
// Top level: range chain, per-entry trim/split logic, sequencer and result word.
//
// Locked page range set. Ranges live in a chain of RANGE_SLOTS cells that
// rotates past one trim/split unit; each operation word (except clear)
// walks every stored range once. Its steps are setup, the scan, the tail
// and append slots, a drain of the sum pipelines, the quota difference and
// the posting of the result; clear goes from setup straight to posting the
// result. A new word is taken whenever the sequencer is idle, even while
// the previous result word still waits on the output.
// Configuration writes are applied at once and should be made while idle.
module locked_page_range_set_unit
  import lpr_pkg::*;
#(
  parameter int RANGE_SLOTS = DEF_RANGE_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lpr_in_if.sink                in_i,
  lpr_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(RANGE_SLOTS);
  localparam int CNT_W = $clog2(RANGE_SLOTS + 1);

  state_e state_d, state_q;

  // Configuration
  logic [QUOTA_W-1:0] quota_q;
  logic               lock_all_q;

  // Operation word and derived bounds
  logic [FUNC_W-1:0]    func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [LEN_W-1:0]     len_q;
  logic [OPPG_W-1:0]    plo_d, plo_q, phi_d, phi_q;
  logic [BYTE_W-1:0]    lo_d, lo_q, hi_d, hi_q, span_q;
  logic [SUM_AL_W-1:0]  sum_al, ep_sum;
  logic                 rm_en_d, rm_en_q, add_ok_d, add_ok_q, cov_en_d, cov_en_q;

  // Counters and flags
  logic [CNT_W-1:0] count_d, count_q, rem_d, rem_q, olen_d, olen_q;
  logic [CNT_W-1:0] scan_pos;
  logic             tail_pend_d, tail_pend_q, drop_d, drop_q, drain_d, drain_q;
  range_t           tail_d, tail_q;
  logic [BYTE_W-1:0] fresh_q;

  // Chain
  range_t           cell_q [RANGE_SLOTS];
  range_t           head, wr_data, scan_data, new_rng;
  cell_ctrl_t       cell_ctrl;
  logic [IDX_W-1:0] wr_idx;
  logic             has_room;

  // Scan decision
  logic [OPPG_W-1:0] hs, he;
  logic              ovl, hd, tl, keep, split;

  // Sums
  acc_in_t           acc_in;
  logic [BYTE_W-1:0] cov_sum, sto_sum;

  // Result
  logic                out_vld_q, load_out;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [REGION_W-1:0] region_d, region_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [COUNT_W-1:0]  rcount_q;
  logic                dropped_q;
  logic [SUM_AL_W:0]   need;

  // ---------------------------------------------------------------------
  // Cell chain: a ring, cell j takes from cell j+1
  for (genvar j = 0; j < RANGE_SLOTS; j++) begin : g_cell
    localparam int NXT = (j + 1) % RANGE_SLOTS;
    lpr_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(j)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .wr_idx_i (wr_idx),
      .wr_data_i(wr_data),
      .next_i   (cell_q[NXT]),
      .data_o   (cell_q[j])
    );
  end

  assign head    = cell_q[0];
  assign new_rng = '{start_pg: plo_q[PG_W-1:0], end_pg: phi_q[END_W-1:0]};

  // Bounds of the operation
  assign sum_al = SUM_AL_W'(addr_q) + SUM_AL_W'(len_q);
  assign ep_sum = sum_al + SUM_AL_W'({PAGE_SHIFT{1'b1}});
  assign plo_d  = OPPG_W'(addr_q[ADDR_BITS-1:PAGE_SHIFT]);
  assign phi_d  = ep_sum[SUM_AL_W-1:PAGE_SHIFT];

  always_comb begin
    lo_d     = BYTE_W'(addr_q);
    hi_d     = BYTE_W'(sum_al);
    rm_en_d  = 1'b0;
    add_ok_d = 1'b0;
    cov_en_d = 1'b0;
    case (func_q)
      FUNC_ADD: begin
        add_ok_d = (len_q != '0) && (phi_d <= (OPPG_W'(1) << PG_W));
        rm_en_d  = add_ok_d;
      end
      FUNC_DEL: begin
        rm_en_d = (len_q != '0);
      end
      FUNC_QUERY: begin
        cov_en_d = (len_q != '0) && !lock_all_q;
      end
      FUNC_GATE: begin
        lo_d     = BYTE_W'({addr_q[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}});
        hi_d     = BYTE_W'({phi_d, {PAGE_SHIFT{1'b0}}});
        cov_en_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Trim, drop or split the head entry
  assign hs    = OPPG_W'(head.start_pg);
  assign he    = OPPG_W'(head.end_pg);
  assign ovl   = rm_en_q && !((phi_q <= hs) || (plo_q >= he));
  assign hd    = hs < plo_q;
  assign tl    = phi_q < he;
  assign keep  = !ovl || hd || tl;
  assign split = ovl && hd && tl;

  always_comb begin
    if (!ovl) begin
      scan_data = head;
    end else if (hd) begin
      scan_data = '{start_pg: head.start_pg, end_pg: END_W'(plo_q)};
    end else begin
      scan_data = '{start_pg: phi_q[PG_W-1:0], end_pg: head.end_pg};
    end
  end

  assign scan_pos = rem_q - CNT_W'(1) + olen_q;
  assign has_room = olen_q < CNT_W'(RANGE_SLOTS);

  // ---------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_SETUP;
      ST_SETUP: begin
        if (func_q == FUNC_CLEAR) begin
          state_d = ST_DONE;
        end else if (count_q == '0) begin
          state_d = ST_TAIL;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN:   if (rem_q == CNT_W'(1)) state_d = ST_TAIL;
      ST_TAIL:   state_d = ST_APPEND;
      ST_APPEND: state_d = ST_DRAIN;
      ST_DRAIN:  if (drain_q) state_d = ST_FRESH;
      ST_FRESH:  state_d = ST_DONE;
      ST_DONE:   if (!out_vld_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready      = 1'b0;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.wr_en = 1'b0;
    wr_idx          = olen_q[IDX_W-1:0];
    wr_data         = scan_data;
    acc_in.clr      = 1'b0;
    acc_in.cov_vld  = 1'b0;
    acc_in.cov_rng  = head;
    acc_in.sto_vld  = 1'b0;
    acc_in.sto_rng  = scan_data;
    count_d         = count_q;
    rem_d           = rem_q;
    olen_d          = olen_q;
    tail_pend_d     = tail_pend_q;
    tail_d          = tail_q;
    drop_d          = drop_q;
    drain_d         = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ST_SETUP: begin
        acc_in.clr  = 1'b1;
        rem_d       = count_q;
        olen_d      = '0;
        tail_pend_d = 1'b0;
        drop_d      = 1'b0;
      end
      ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        cell_ctrl.wr_en = keep;
        wr_idx          = scan_pos[IDX_W-1:0];
        acc_in.cov_vld  = cov_en_q;
        acc_in.sto_vld  = keep;
        rem_d           = rem_q - CNT_W'(1);
        olen_d          = olen_q + CNT_W'(keep);
        if (split) begin
          tail_pend_d = 1'b1;
          tail_d      = '{start_pg: phi_q[PG_W-1:0], end_pg: head.end_pg};
        end
      end
      ST_TAIL: begin
        wr_data        = tail_q;
        acc_in.sto_rng = tail_q;
        if (tail_pend_q) begin
          if (has_room) begin
            cell_ctrl.wr_en = 1'b1;
            acc_in.sto_vld  = 1'b1;
            olen_d          = olen_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      ST_APPEND: begin
        wr_data        = new_rng;
        acc_in.sto_rng = new_rng;
        if (add_ok_q) begin
          if (has_room) begin
            cell_ctrl.wr_en = 1'b1;
            acc_in.sto_vld  = 1'b1;
            olen_d          = olen_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        drain_d = !drain_q;
      end
      ST_FRESH: ;
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          load_out = 1'b1;
          count_d  = olen_q;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  assign need = (SUM_AL_W + 1)'(sto_sum) + (SUM_AL_W + 1)'(fresh_q);

  always_comb begin
    status_d = GATE_OK;
    region_d = '0;
    if (func_q == FUNC_GATE) begin
      if (quota_q == '1) begin
        status_d = GATE_OK;
      end else if (quota_q == '0) begin
        status_d = GATE_FORBID;
      end else if ((len_q != '0) && (QUOTA_W'(need) > quota_q)) begin
        status_d = GATE_OVER;
      end
    end
    if ((func_q == FUNC_QUERY) && (len_q != '0)) begin
      region_d = lock_all_q ? REGION_W'(len_q) : REGION_W'(cov_sum);
    end
  end

  // ---------------------------------------------------------------------
  // Sum pipelines
  lpr_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc_in),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .cov_sum_o(cov_sum),
    .sto_sum_o(sto_sum)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quota_q     <= '1;
      lock_all_q  <= 1'b0;
      count_q     <= '0;
      rem_q       <= '0;
      olen_q      <= '0;
      tail_pend_q <= 1'b0;
      drop_q      <= 1'b0;
      drain_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      olen_q      <= olen_d;
      tail_pend_q <= tail_pend_d;
      drop_q      <= drop_d;
      drain_q     <= drain_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_QUOTA:    quota_q    <= cfg_data_i;
          CFG_LOCK_ALL: lock_all_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      addr_q <= in_i.start_addr;
      len_q  <= in_i.length;
    end
    if (state_q == ST_SETUP) begin
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      rm_en_q  <= rm_en_d;
      add_ok_q <= add_ok_d;
      cov_en_q <= cov_en_d;
    end
    tail_q <= tail_d;
    span_q <= hi_q - lo_q;
    if (state_q == ST_FRESH) begin
      fresh_q <= span_q - cov_sum;
    end
    if (load_out) begin
      status_q  <= status_d;
      region_q  <= region_d;
      total_q   <= TOTAL_W'(sto_sum);
      rcount_q  <= COUNT_W'(olen_q);
      dropped_q <= drop_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = status_q;
  assign out_o.region_bytes = region_q;
  assign out_o.total_locked = total_q;
  assign out_o.range_count  = rcount_q;
  assign out_o.dropped      = dropped_q;

  // ---------------------------------------------------------------------
  // Checks
  a_olen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    olen_q <= CNT_W'(RANGE_SLOTS))
    else $error("working range count above slot count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RANGE_SLOTS))
    else $error("stored range count above slot count");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q != '0))
    else $error("scan with no entries left");

  a_scan_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((rem_q + olen_q) <= count_q))
    else $error("scan produced more entries than it consumed");

  a_split_needs_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && split) |-> (rm_en_q && !tail_pend_q))
    else $error("split without remove, or second split");

  a_drop_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && drop_q) |-> ((func_q == FUNC_ADD) || (func_q == FUNC_DEL)))
    else $error("drop flagged for an operation that stores nothing");

endmodule

// File: bench/locked_page_range_set_unit_tb.sv
// Self-checking bench for the locked page range set unit: directed table and random ops.
module locked_page_range_set_unit_tb
  import lpr_pkg::*;
();

  localparam int          SLOTS         = DEF_RANGE_SLOTS;
  localparam longint      CYCLE_LIMIT   = 6_000_000;
  localparam bit [63:0]   QUOTA_NONE    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [63:0]   PG_MASK       = 64'hFFF;
  localparam bit [63:0]   PG_LIMIT      = 64'd1 << (ADDR_BITS - PAGE_SHIFT);
  localparam bit [48:0]   LEN_FULL      = 49'd1 << ADDR_BITS;
  localparam bit [47:0]   ADDR_TOP      = 48'hFFFF_FFFF_FFFF;
  localparam bit [2:0]    FUNC_RSVD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

  typedef struct packed {
    bit [STATUS_W-1:0] status;
    bit [REGION_W-1:0] region;
    bit [TOTAL_W-1:0]  total;
    bit [COUNT_W-1:0]  count;
    bit                dropped;
  } lock_res_t;

  typedef struct {
    bit        is_cfg;
    bit [2:0]  code;
    bit [63:0] addr;
    bit [48:0] len;
    bit        typed;
    lock_res_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpr_in_if  in_if();
  lpr_out_if out_if();

  locked_page_range_set_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: shadow range table and registers
  bit [63:0]   shadow_lo [SLOTS];
  bit [63:0]   shadow_hi [SLOTS];
  int unsigned shadow_used;
  bit [63:0]   quota_reg;
  bit          lock_all_reg;

  lock_res_t   pending_words[$];
  stim_row_t   stim_rows[$];
  int          mismatches = 0;
  int          words_sent;
  int          words_checked = 0;
  int          peak_ranges;
  longint      cycles = 0;
  bit          no_idle;

  // Cut pages [plo, phi) out of the shadow table; return 1 if a split tail was lost
  function automatic bit cut_pages(bit [63:0] plo, bit [63:0] phi);
    bit          lost;
    int unsigned i;
    bit [63:0]   a;
    bit [63:0]   b;
    bit          head;
    bit          tail;
    lost = 1'b0;
    i = 0;
    while (i < shadow_used) begin
      a = shadow_lo[i];
      b = shadow_hi[i];
      if (phi <= a || plo >= b) begin
        i++;
        continue;
      end
      head = a < plo;
      tail = phi < b;
      if (!head && !tail) begin
        shadow_used--;
        shadow_lo[i] = shadow_lo[shadow_used];
        shadow_hi[i] = shadow_hi[shadow_used];
        continue;
      end
      if (head) shadow_hi[i] = plo;
      else shadow_lo[i] = phi;
      if (head && tail) begin
        if (shadow_used < SLOTS) begin
          shadow_lo[shadow_used] = phi;
          shadow_hi[shadow_used] = b;
          shadow_used++;
        end else begin
          lost = 1'b1;
        end
      end
      i++;
    end
    return lost;
  endfunction

  // Locked bytes of byte region [lo, hi)
  function automatic bit [63:0] covered_in(bit [63:0] lo, bit [63:0] hi);
    bit [63:0] sum;
    bit [63:0] a;
    bit [63:0] b;
    sum = 0;
    for (int unsigned i = 0; i < shadow_used; i++) begin
      a = shadow_lo[i] << PAGE_SHIFT;
      b = shadow_hi[i] << PAGE_SHIFT;
      if (a < lo) a = lo;
      if (b > hi) b = hi;
      if (b > a) sum += b - a;
    end
    return sum;
  endfunction

  function automatic bit [63:0] locked_total();
    bit [63:0] sum;
    sum = 0;
    for (int unsigned i = 0; i < shadow_used; i++)
      sum += (shadow_hi[i] - shadow_lo[i]) << PAGE_SHIFT;
    return sum;
  endfunction

  function automatic void shadow_write(bit [1:0] idx, bit [63:0] data);
    if (idx == CFG_QUOTA) quota_reg = data;
    else if (idx == CFG_LOCK_ALL) lock_all_reg = data[0];
  endfunction

  // Apply one operation word to the shadow table and return its result word
  function automatic lock_res_t apply_op(bit [2:0] f, bit [47:0] addr_in, bit [48:0] len_in);
    lock_res_t r;
    bit [63:0] addr;
    bit [63:0] len;
    bit [63:0] plo;
    bit [63:0] phi;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] fresh;
    bit [63:0] region;
    bit [63:0] total;
    bit        lost;
    addr = 64'(addr_in);
    len = 64'(len_in);
    r = '0;
    region = 0;
    lost = 1'b0;
    plo = addr >> PAGE_SHIFT;
    phi = (addr + len + PG_MASK) >> PAGE_SHIFT;
    case (f)
      FUNC_ADD: begin
        if (len != 0 && phi <= PG_LIMIT && phi > plo) begin
          lost = cut_pages(plo, phi);
          if (shadow_used < SLOTS) begin
            shadow_lo[shadow_used] = plo;
            shadow_hi[shadow_used] = phi;
            shadow_used++;
          end else begin
            lost = 1'b1;
          end
        end
      end
      FUNC_DEL: begin
        if (len != 0 && shadow_used != 0) lost = cut_pages(plo, phi);
      end
      FUNC_QUERY: begin
        if (len != 0) region = lock_all_reg ? len : covered_in(addr, addr + len);
      end
      FUNC_GATE: begin
        if (quota_reg == QUOTA_NONE) begin
          r.status = GATE_OK;
        end else if (quota_reg == 0) begin
          r.status = GATE_FORBID;
        end else if (len != 0) begin
          lo = addr & ~PG_MASK;
          hi = phi << PAGE_SHIFT;
          fresh = (hi - lo) - covered_in(lo, hi);
          if (locked_total() + fresh > quota_reg) r.status = GATE_OVER;
        end
      end
      FUNC_CLEAR: begin
        shadow_used = 0;
      end
      default: ;
    endcase
    total     = locked_total();
    r.region  = region[48:0];
    r.total   = total[48:0];
    r.count   = shadow_used[10:0];
    r.dropped = lost;
    if (shadow_used > peak_ranges) peak_ranges = shadow_used;
    return r;
  endfunction

  function automatic void add_row(bit is_cfg, bit [2:0] code, bit [63:0] addr, bit [48:0] len,
                                  bit typed, lock_res_t res);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.code   = code;
    row.addr   = addr;
    row.len    = len;
    row.typed  = typed;
    row.res    = res;
    stim_rows.push_back(row);
  endfunction

  function automatic bit [47:0] rand_addr();
    int unsigned w;
    bit [63:0]   raw;
    w = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (w < 75) return 48'($urandom_range(0, 256 * 4096 - 1));
    if (w < 88) return raw[47:0];
    return ADDR_TOP - 48'($urandom_range(0, 65535));
  endfunction

  function automatic bit [48:0] rand_len();
    int unsigned w;
    bit [63:0]   raw;
    w = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (w < 8) return '0;
    if (w < 70) return 49'($urandom_range(1, 5 * 4096));
    if (w < 85) return 49'($urandom_range(1, 16)) << PAGE_SHIFT;
    if (w < 95) return 49'(raw[47:0] >> $urandom_range(0, 40));
    return LEN_FULL;
  endfunction

  function automatic bit [2:0] rand_func();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 35) return FUNC_ADD;
    if (w < 55) return FUNC_DEL;
    if (w < 72) return FUNC_QUERY;
    if (w < 90) return FUNC_GATE;
    if (w < 93) return FUNC_CLEAR;
    return FUNC_RSVD + 3'($urandom_range(0, 2));
  endfunction

  // Offer one word, hold it until accepted, then record its prediction
  task automatic send_word(bit [2:0] f, bit [47:0] a, bit [48:0] l, bit typed, lock_res_t res);
    int        gap;
    bit        taken;
    lock_res_t p;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= f;
    in_if.start_addr <= a;
    in_if.length     <= l;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    p = apply_op(f, a, l);
    pending_words.push_back(typed ? res : p);
    words_sent++;
  endtask

  // Hold off until every result word is back and the block has settled
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [63:0] data);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    shadow_write(idx, data);
  endtask

  // Drain result words with random stalls and check each against the oldest prediction
  initial begin
    int        stall;
    lock_res_t want;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (!(out_if.valid && out_if.ready));
      if (pending_words.size() == 0) begin
        $error("unexpected result word: total_locked %0h count %0d",
               out_if.total_locked, out_if.range_count);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.region_bytes !== want.region) begin
          $error("region_bytes: expected %0h, got %0h", want.region, out_if.region_bytes);
          mismatches++;
        end
        if (out_if.total_locked !== want.total) begin
          $error("total_locked: expected %0h, got %0h", want.total, out_if.total_locked);
          mismatches++;
        end
        if (out_if.range_count !== want.count) begin
          $error("range_count: expected %0d, got %0d", want.count, out_if.range_count);
          mismatches++;
        end
        if (out_if.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_if.dropped);
          mismatches++;
        end
      end
      @(posedge clk_i);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit [63:0] q;
    words_sent    = 0;
    peak_ranges   = 0;
    no_idle       = 1'b0;
    shadow_used   = 0;
    quota_reg     = QUOTA_NONE;
    lock_all_reg  = 1'b0;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.func       <= '0;
    in_if.start_addr <= '0;
    in_if.length     <= '0;

    // Directed table: extremes, every operation, special cases
    add_row(0, FUNC_QUERY, 0, 4096, 1, '{GATE_OK, 0, 0, 0, 0});
    add_row(0, FUNC_GATE, 0, 1, 1, '{GATE_OK, 0, 0, 0, 0});
    add_row(0, FUNC_ADD, 64'h1000, 0, 1, '{GATE_OK, 0, 0, 0, 0});
    add_row(0, FUNC_ADD, 64'hFFFF_FFFF_F000, 49'h1000, 0, '0);
    add_row(0, FUNC_ADD, ADDR_TOP, 2, 0, '0);
    add_row(0, FUNC_ADD, 0, LEN_FULL, 1, '{GATE_OK, 0, LEN_FULL, 1, 0});
    add_row(0, FUNC_QUERY, 0, LEN_FULL, 1, '{GATE_OK, LEN_FULL, LEN_FULL, 1, 0});
    add_row(0, FUNC_DEL, 64'h5000, 49'h1000, 0, '0);
    add_row(0, FUNC_DEL, ADDR_TOP, LEN_FULL, 0, '0);
    add_row(0, FUNC_RSVD, 64'h2000, 49'h1000, 0, '0);
    add_row(0, FUNC_RSVD + 3'd1, ADDR_TOP, LEN_FULL, 0, '0);
    add_row(0, FUNC_RSVD + 3'd2, 0, 0, 0, '0);
    add_row(0, FUNC_ADD, 64'h3, 49'h10, 0, '0);
    add_row(0, FUNC_QUERY, 64'h4ABC, 49'h2345, 0, '0);
    add_row(0, FUNC_GATE, 64'h10, 49'h2000, 0, '0);
    add_row(0, FUNC_CLEAR, ADDR_TOP, LEN_FULL, 1, '{GATE_OK, 0, 0, 0, 0});
    add_row(0, FUNC_DEL, 0, LEN_FULL, 1, '{GATE_OK, 0, 0, 0, 0});
    add_row(1, CFG_QUOTA, 0, 0, 0, '0);
    add_row(0, FUNC_GATE, 0, 0, 1, '{GATE_FORBID, 0, 0, 0, 0});
    add_row(0, FUNC_GATE, ADDR_TOP, LEN_FULL, 1, '{GATE_FORBID, 0, 0, 0, 0});
    add_row(1, CFG_QUOTA, 64'h3000, 0, 0, '0);
    add_row(0, FUNC_ADD, 0, 49'h2000, 0, '0);
    add_row(0, FUNC_GATE, 0, 49'h4000, 0, '0);
    add_row(0, FUNC_GATE, 64'h1000, 1, 0, '0);
    add_row(1, CFG_LOCK_ALL, 1, 0, 0, '0);
    add_row(0, FUNC_QUERY, 5, 123, 0, '0);
    add_row(0, FUNC_QUERY, 0, LEN_FULL, 0, '0);
    add_row(1, CFG_UNUSED, 0, 0, 0, '0);
    add_row(0, FUNC_QUERY, 64'h7, 49'h1, 0, '0);
    add_row(1, CFG_LOCK_ALL, 0, 0, 0, '0);
    add_row(1, CFG_QUOTA, QUOTA_NONE, 0, 0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_reg(stim_rows[i].code[1:0], stim_rows[i].addr);
      else send_word(stim_rows[i].code, stim_rows[i].addr[47:0], stim_rows[i].len,
                     stim_rows[i].typed, stim_rows[i].res);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: q = QUOTA_NONE;
        1: q = 0;
        2: q = (64'($urandom_range(1, 64)) << PAGE_SHIFT) | 64'($urandom_range(0, 4095));
        3: q = QUOTA_NONE - 1;
        4: q = {$urandom, $urandom};
        default: q = 64'($urandom_range(1, 1 << 20));
      endcase
      write_reg(CFG_QUOTA, q);
      write_reg(CFG_LOCK_ALL, 64'(ph[0]));
      no_idle = (ph == 4);
      for (int n = 0; n < 97; n++) begin
        if (ph == 2 && n == 48) wait_drained();
        send_word(rand_func(), rand_addr(), rand_len(), 0, '0);
      end
    end

    // Drain and report
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 20) @(posedge clk_i);
    $display("tb: %0d operation words sent, %0d result words checked", words_sent,
             words_checked);
    $display("tb: table reached %0d ranges, six register settings exercised", peak_ranges);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
src/lpr_pkg.sv
src/lpr_if.sv
src/lpr_cell.sv
src/lpr_accum.sv
src/locked_page_range_set_unit.sv
bench/locked_page_range_set_unit_tb.sv
